[src/isss_pkg.sv]
//==============================================================================
// isss_pkg
// Shared types, codes and constants of the sweep sequencer.
//==============================================================================
`default_nettype none

package isss_pkg;

    // Default number of sweep slots.
    localparam int SlotsDefault = 4;

    // Request operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_NOTE   = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  slot;
        logic [15:0] note_pair;
        logic [15:0] duty_pair;
        logic [15:0] attack_pair;
        logic [15:0] decay_pair;
        logic [15:0] wave_pair;
        logic [15:0] pan_pair;
        logic [7:0]  hold_frames;
        logic [7:0]  release_len;
        logic [7:0]  step_total;
        logic        repeat_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        slot_id;
        logic [7:0]        note;
        logic [7:0]        duration;
        logic [7:0]        release_res;
        logic [7:0]        duty;
        logic [7:0]        attack_vol;
        logic [7:0]        decay_vol;
        logic [7:0]        wave;
        logic signed [7:0] pan;
        logic              last;
    } out_item_t;

    // Stored sweep setup of one slot.
    typedef struct packed {
        logic [15:0] note_ends;
        logic [15:0] duty_ends;
        logic [15:0] attack_ends;
        logic [15:0] decay_ends;
        logic [15:0] wave_ends;
        logic [15:0] pan_ends;
        logic [7:0]  hold_len;
        logic [7:0]  release_store;
        logic [7:0]  step_count;
        logic        loops;
    } slot_cfg_t;

    // Complete content of one slot cell, passed around the ring.
    typedef struct packed {
        logic       active;
        slot_cfg_t  cfg;
        logic [7:0] step_index;
        logic [7:0] frame_count;
    } slot_state_t;

endpackage

`default_nettype wire

[src/interpolated_sound_sweep_sequencer.sv]
//==============================================================================
// interpolated_sound_sweep_sequencer
// Bank of linear sweep slots held in a rotating ring of cells.
//==============================================================================
// Usage:
//   Requests enter on in_valid/in_ready with an in_item_t payload; results
//   leave on out_valid/out_ready as out_item_t. A start gives one result
//   (accepted with the claimed slot, or rejected). A stop and an unused op
//   give none. A tick gives one note result per firing slot, in slot order,
//   with last set on the final one.
//   The slots sit in a ring of SLOTS cells that rotates one place per cycle
//   except while the dividers run or a note waits for the output; a request
//   is served by walking the whole ring once, the head cell being examined
//   and updated as it passes. A start or a stop then ends in the done state,
//   which loads the start's result into the output register and returns to
//   idle, where the next request can be taken. For each firing slot of a
//   tick the ring halts while the six serial dividers find 17 quotient bits,
//   and the note is then handed over as the ring moves on.
//   One request is processed at a time; in_ready is low while busy.
//   Reset clears all slots to inactive. When the receiver stalls, the output
//   register holds its result and the ring waits before handing over a note.
//==============================================================================
`default_nettype none

module interpolated_sound_sweep_sequencer #(
    parameter int SLOTS = isss_pkg::SlotsDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire isss_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output isss_pkg::out_item_t     out_data
);

    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    isss_pkg::in_item_t req_reg, req_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic found_reg, found_next;
    logic [1:0] found_id_reg, found_id_next;
    logic any_reg, any_next;
    isss_pkg::out_item_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;
    isss_pkg::out_item_t note_reg, note_next;
    logic note_pend_reg, note_pend_next;

    isss_pkg::slot_state_t cell_q [SLOTS];
    isss_pkg::slot_state_t cell_d [SLOTS];
    isss_pkg::slot_state_t head_new;
    logic shift;

    logic div_start;
    logic [5:0] div_done;
    logic [7:0] div_res [6];
    logic [15:0] div_pair [6];

    // Ring of cells: each takes its neighbor; the last takes the updated head.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        if (g == SLOTS - 1)
        begin : g_tail
            assign cell_d[g] = head_new;
        end
        else
        begin : g_mid
            assign cell_d[g] = cell_q[g+1];
        end
        isss_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d[g]),
            .q     (cell_q[g])
        );
    end

    // Six interpolators working on the head cell.
    assign div_pair[0] = cell_q[0].cfg.note_ends;
    assign div_pair[1] = cell_q[0].cfg.duty_ends;
    assign div_pair[2] = cell_q[0].cfg.attack_ends;
    assign div_pair[3] = cell_q[0].cfg.decay_ends;
    assign div_pair[4] = cell_q[0].cfg.wave_ends;
    assign div_pair[5] = cell_q[0].cfg.pan_ends;

    for (genvar k = 0; k < 6; k++)
    begin : g_div
        isss_lerp u_lerp (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (div_start),
            .pair      (div_pair[k]),
            .is_signed (k == 5),
            .step      (cell_q[0].step_index),
            .total     (cell_q[0].cfg.step_count),
            .done      (div_done[k]),
            .result    (div_res[k])
        );
    end

    logic out_free;
    logic [7:0] fc_inc;
    logic fire;
    logic [1:0] pos_id;
    logic [7:0] st_inc;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        found_id_next  = found_id_reg;
        any_next       = any_reg;
        obuf_next      = obuf_reg;
        ovalid_next    = ovalid_reg;
        note_next      = note_reg;
        note_pend_next = note_pend_reg;
        head_new       = cell_q[0];
        shift          = 1'b0;
        div_start      = 1'b0;
        out_free       = !ovalid_reg || out_ready;
        fc_inc         = cell_q[0].frame_count + 8'd1;
        fire           = cell_q[0].active && !(fc_inc < cell_q[0].cfg.hold_len);
        pos_id         = 2'(pos_reg);
        st_inc         = cell_q[0].step_index + 8'd1;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    pos_next   = '0;
                    found_next = 1'b0;
                    any_next   = 1'b0;
                    found_id_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (pos_reg == CW'(SLOTS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (req_reg.op)
                        isss_pkg::OP_START:
                        begin
                            if (!found_reg && !cell_q[0].active && req_reg.step_total != 8'd0)
                            begin
                                found_next    = 1'b1;
                                found_id_next = pos_id;
                                head_new.active = 1'b1;
                                head_new.step_index  = '0;
                                head_new.frame_count = '0;
                                head_new.cfg.note_ends   = req_reg.note_pair;
                                head_new.cfg.duty_ends   = req_reg.duty_pair;
                                head_new.cfg.attack_ends = req_reg.attack_pair;
                                head_new.cfg.decay_ends  = req_reg.decay_pair;
                                head_new.cfg.wave_ends   = req_reg.wave_pair;
                                head_new.cfg.pan_ends    = req_reg.pan_pair;
                                head_new.cfg.hold_len    = req_reg.hold_frames;
                                head_new.cfg.release_store = req_reg.release_len;
                                head_new.cfg.step_count  = req_reg.step_total;
                                head_new.cfg.loops       = req_reg.repeat_req;
                            end
                            shift    = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                        isss_pkg::OP_STOP:
                        begin
                            if (int'(req_reg.slot) == int'(pos_reg))
                            begin
                                head_new.active = 1'b0;
                            end
                            shift    = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                        isss_pkg::OP_TICK:
                        begin
                            if (fire)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                if (cell_q[0].active)
                                begin
                                    head_new.frame_count = fc_inc;
                                end
                                shift    = 1'b1;
                                pos_next = pos_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            shift    = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done[0])
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Emit the previously held note, keep the new one pending.
                if (!note_pend_reg || out_free)
                begin
                    if (note_pend_reg)
                    begin
                        obuf_next   = note_reg;
                        ovalid_next = 1'b1;
                    end
                    note_next.kind        = isss_pkg::KIND_NOTE;
                    note_next.slot_id     = pos_id;
                    note_next.note        = div_res[0];
                    note_next.duration    = cell_q[0].cfg.hold_len;
                    note_next.release_res = (st_inc == cell_q[0].cfg.step_count
                                             && !cell_q[0].cfg.loops)
                                            ? cell_q[0].cfg.release_store : 8'd0;
                    note_next.duty        = div_res[1];
                    note_next.attack_vol  = div_res[2];
                    note_next.decay_vol   = div_res[3];
                    note_next.wave        = div_res[4];
                    note_next.pan         = div_res[5];
                    note_next.last        = 1'b0;
                    note_pend_next = 1'b1;
                    any_next = 1'b1;
                    head_new.frame_count = '0;
                    head_new.step_index  = st_inc;
                    if (!(st_inc < cell_q[0].cfg.step_count))
                    begin
                        if (cell_q[0].cfg.loops)
                        begin
                            head_new.step_index = '0;
                        end
                        else
                        begin
                            head_new.active = 1'b0;
                        end
                    end
                    shift      = 1'b1;
                    pos_next   = pos_reg + CW'(1);
                    state_next = ST_WALK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (req_reg.op == isss_pkg::OP_START)
                    begin
                        obuf_next = '0;
                        obuf_next.kind = found_reg ? isss_pkg::KIND_ACCEPT
                                                   : isss_pkg::KIND_REJECT;
                        obuf_next.slot_id = found_reg ? found_id_reg : 2'd0;
                        obuf_next.last = 1'b1;
                        ovalid_next = 1'b1;
                    end
                    else if (note_pend_reg)
                    begin
                        obuf_next = note_reg;
                        obuf_next.last = 1'b1;
                        ovalid_next = 1'b1;
                    end
                    note_pend_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovalid_reg    <= 1'b0;
            note_pend_reg <= 1'b0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovalid_reg    <= ovalid_next;
            note_pend_reg <= note_pend_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        found_id_reg <= found_id_next;
        obuf_reg     <= obuf_next;
        note_reg     <= note_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    // A pending note exists only after some slot fired during this tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        note_pend_reg |-> any_reg)
        else $error("pending note without a firing slot");

    // The walk position never passes the ring length.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CW'(SLOTS))
        else $error("ring position out of range");

    // Dividers finish only while waiting for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> state_reg == ST_DIV)
        else $error("divider result outside divide state");

    // A new request is only taken when idle and no note is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !note_pend_reg)
        else $error("request accepted with a pending note");

endmodule

`default_nettype wire

[src/isss_cell.sv]
//==============================================================================
// isss_cell
// One slot cell of the rotating ring; loads either its neighbor or an update.
//==============================================================================
`default_nettype none

module isss_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire isss_pkg::slot_state_t d,
    output isss_pkg::slot_state_t     q
);

    isss_pkg::slot_state_t state_reg;
    isss_pkg::slot_state_t state_next;

    // Hold or take the value handed in by the neighbor.
    always_comb
    begin
        state_next = state_reg;
        if (shift)
        begin
            state_next = d;
        end
    end

    // The active flag, the counters and the stored setup all get a reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active      <= 1'b0;
            state_reg.step_index  <= '0;
            state_reg.frame_count <= '0;
            state_reg.cfg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

`default_nettype wire

[src/isss_lerp.sv]
//==============================================================================
// isss_lerp
// Serial restoring divider: one interpolated byte, one quotient bit a cycle.
//==============================================================================
`default_nettype none

module isss_lerp (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [15:0] pair,
    input  wire logic       is_signed,
    input  wire logic [7:0] step,
    input  wire logic [7:0] total,
    output logic            done,
    output logic [7:0]      result
);

    // |(b-a)*step| < 2^16, so 17 quotient bits are enough.
    localparam int QW = 17;

    logic            busy_reg, busy_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [QW-1:0]   num_reg, num_next;
    logic [7:0]      den_reg, den_next;
    logic [8:0]      rem_reg, rem_next;
    logic            neg_reg, neg_next;
    logic signed [9:0] a_reg, a_next;
    logic            one_reg, one_next;
    logic            done_reg, done_next;
    logic [7:0]      res_reg, res_next;

    logic signed [9:0]  a_w, b_w, diff_w;
    logic signed [18:0] prod_w;
    logic [18:0]        mag_w;
    logic [9:0]         trial_w;
    logic [QW-1:0]      q_w;
    logic signed [18:0] r_w;

    always_comb
    begin
        a_w = is_signed ? {{2{pair[7]}}, pair[7:0]} : {2'b00, pair[7:0]};
        b_w = is_signed ? {{2{pair[15]}}, pair[15:8]} : {2'b00, pair[15:8]};
        diff_w = b_w - a_w;
        prod_w = 19'(diff_w) * $signed({11'd0, step});
        mag_w = prod_w[18] ? 19'(-prod_w) : prod_w;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        one_next  = one_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        trial_w   = {rem_reg, num_reg[QW-1]} - {2'b00, den_reg};
        q_w       = '0;
        r_w       = '0;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(QW);
            num_next  = mag_w[QW-1:0];
            den_next  = total - 8'd1;
            rem_next  = '0;
            neg_next  = prod_w[18];
            a_next    = a_w;
            one_next  = (total <= 8'd1);
        end
        else if (busy_reg)
        begin
            // One shift-subtract step.
            if (!trial_w[9])
            begin
                rem_next = trial_w[8:0];
                num_next = {num_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[7:0], num_reg[QW-1]};
                num_next = {num_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_w = num_next;
                r_w = neg_reg ? -$signed({2'b00, q_w}) : $signed({2'b00, q_w});
                res_next = one_reg ? a_reg[7:0] : 8'(19'(a_reg) + r_w);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        one_reg <= one_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[test/tb_interpolated_sound_sweep_sequencer.sv]
//==============================================================================
// tb_interpolated_sound_sweep_sequencer
// Drives start, stop, tick and stray requests with random gaps on both channels and
// checks every note and start result against an in-bench sweep predictor.
//==============================================================================
`default_nettype none

module tb_interpolated_sound_sweep_sequencer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 4;
    localparam int CYCLE_LIMIT = 1500000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    isss_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    isss_pkg::out_item_t out_data;

    interpolated_sound_sweep_sequencer #(.SLOTS(NSLOT)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Predictor copy of the slot bank.
    logic                sw_active [NSLOT];
    isss_pkg::slot_cfg_t sw_cfg    [NSLOT];
    logic [7:0]          sw_step   [NSLOT];
    logic [7:0]          sw_frames [NSLOT];

    isss_pkg::in_item_t  pending_requests[$];
    isss_pkg::out_item_t expected_results[$];
    int        error_count;
    int        cycle_count;
    bit        stimulus_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Linear interpolation of one byte pair, truncating toward zero.
    function automatic logic [7:0] sweep_value(input logic [15:0] pair, input bit sgn,
                                               input logic [7:0] st,
                                               input logic [7:0] tot);
        int a;
        int b;
        int r;
        if (sgn)
        begin
            a = int'($signed(pair[7:0]));
            b = int'($signed(pair[15:8]));
        end
        else
        begin
            a = int'(pair[7:0]);
            b = int'(pair[15:8]);
        end
        if (tot <= 1)
            r = a;
        else
            r = a + ((b - a) * int'(st)) / (int'(tot) - 1);
        return r[7:0];
    endfunction

    // Advance the predicted slot bank by one request and queue its results.
    task automatic predict_sweep(input isss_pkg::in_item_t req);
        isss_pkg::out_item_t res;
        int found;
        int first_idx;
        bit fin;
        found = -1;
        first_idx = expected_results.size();
        res = '0;
        if (req.op == isss_pkg::OP_START)
        begin
            if (req.step_total != 0)
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!sw_active[i])
                        found = i;
            if (found < 0)
                res.kind = isss_pkg::KIND_REJECT;
            else
            begin
                sw_cfg[found] = '{req.note_pair, req.duty_pair, req.attack_pair,
                                  req.decay_pair, req.wave_pair, req.pan_pair,
                                  req.hold_frames, req.release_len, req.step_total,
                                  req.repeat_req};
                sw_step[found] = '0;
                sw_frames[found] = '0;
                sw_active[found] = 1'b1;
                res.kind = isss_pkg::KIND_ACCEPT;
                res.slot_id = 2'(found);
            end
            res.last = 1'b1;
            expected_results.push_back(res);
        end
        else if (req.op == isss_pkg::OP_STOP)
            sw_active[req.slot] = 1'b0;
        else if (req.op == isss_pkg::OP_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!sw_active[i])
                    continue;
                sw_frames[i] = sw_frames[i] + 8'd1;
                if (sw_frames[i] < sw_cfg[i].hold_len)
                    continue;
                sw_frames[i] = '0;
                fin = (int'(sw_step[i]) + 1 == int'(sw_cfg[i].step_count));
                res = '0;
                res.kind = isss_pkg::KIND_NOTE;
                res.slot_id = 2'(i);
                res.note = sweep_value(sw_cfg[i].note_ends, 0, sw_step[i], sw_cfg[i].step_count);
                res.duration = sw_cfg[i].hold_len;
                res.release_res = (fin && !sw_cfg[i].loops) ? sw_cfg[i].release_store : 8'd0;
                res.duty = sweep_value(sw_cfg[i].duty_ends, 0, sw_step[i], sw_cfg[i].step_count);
                res.attack_vol = sweep_value(sw_cfg[i].attack_ends, 0, sw_step[i],
                                             sw_cfg[i].step_count);
                res.decay_vol = sweep_value(sw_cfg[i].decay_ends, 0, sw_step[i],
                                            sw_cfg[i].step_count);
                res.wave = sweep_value(sw_cfg[i].wave_ends, 0, sw_step[i], sw_cfg[i].step_count);
                res.pan = sweep_value(sw_cfg[i].pan_ends, 1, sw_step[i], sw_cfg[i].step_count);
                expected_results.push_back(res);
                sw_step[i] = sw_step[i] + 8'd1;
                if (sw_step[i] >= sw_cfg[i].step_count)
                begin
                    if (sw_cfg[i].loops)
                        sw_step[i] = '0;
                    else
                        sw_active[i] = 1'b0;
                end
            end
            if (expected_results.size() > first_idx)
                expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endtask

    // Random gap length: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic isss_pkg::in_item_t random_start(input int max_steps,
                                                        input int max_hold);
        isss_pkg::in_item_t t;
        t = isss_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
        t.op = isss_pkg::OP_START;
        t.step_total = 8'($urandom_range(max_steps, 1));
        t.hold_frames = 8'($urandom_range(max_hold));
        return t;
    endfunction

    // Driver: one request at a time, random idle between requests.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end
        else if (pending_requests.size() > 0)
        begin
            if (in_valid)
                in_gap <= pick_gap();
            if (in_valid && in_gap == 0 && pick_gap() > 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data <= pending_requests.pop_front();
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Prediction runs on each accepted request.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            predict_sweep(in_data);

    // Monitor: random receiver stalls, compare each accepted result.
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        isss_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", out_data));
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d want %0d", out_data.kind, want.kind));
                    if (out_data.slot_id !== want.slot_id)
                        report_mismatch($sformatf("slot_id %0d want %0d",
                                                  out_data.slot_id, want.slot_id));
                    if (out_data.note !== want.note)
                        report_mismatch($sformatf("note %0d want %0d", out_data.note, want.note));
                    if (out_data.duration !== want.duration)
                        report_mismatch($sformatf("duration %0d want %0d",
                                                  out_data.duration, want.duration));
                    if (out_data.release_res !== want.release_res)
                        report_mismatch($sformatf("release %0d want %0d",
                                                  out_data.release_res, want.release_res));
                    if (out_data.duty !== want.duty)
                        report_mismatch($sformatf("duty %0d want %0d", out_data.duty, want.duty));
                    if (out_data.attack_vol !== want.attack_vol)
                        report_mismatch($sformatf("attack %0d want %0d",
                                                  out_data.attack_vol, want.attack_vol));
                    if (out_data.decay_vol !== want.decay_vol)
                        report_mismatch($sformatf("decay %0d want %0d",
                                                  out_data.decay_vol, want.decay_vol));
                    if (out_data.wave !== want.wave)
                        report_mismatch($sformatf("wave %0d want %0d", out_data.wave, want.wave));
                    if (out_data.pan !== want.pan)
                        report_mismatch($sformatf("pan %0d want %0d", out_data.pan, want.pan));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %0d want %0d", out_data.last, want.last));
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else if (out_ready && pick_gap() > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_interpolated_sound_sweep_sequencer: FAIL");
            $finish;
        end
    end

    initial
    begin
        isss_pkg::in_item_t t;
        int kind_pick;
        error_count = 0;
        cycle_count = 0;
        stimulus_done = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sw_active[i] = 1'b0;
            sw_step[i] = '0;
            sw_frames[i] = '0;
            sw_cfg[i] = '0;
        end

        // Directed: zero-step reject, extremes, single step, hold zero, full bank.
        t = '0; t.op = isss_pkg::OP_START; t.step_total = 8'd0;
        pending_requests.push_back(t);
        t = '1; t.op = isss_pkg::OP_START; t.hold_frames = 8'd0; t.step_total = 8'd255;
        t.repeat_req = 1'b0;
        pending_requests.push_back(t);
        t = '0; t.op = isss_pkg::OP_START; t.note_pair = 16'hFF00; t.pan_pair = 16'h7F80;
        t.duty_pair = 16'h00FF; t.hold_frames = 8'd1; t.step_total = 8'd1; t.release_len = 8'hA5;
        pending_requests.push_back(t);
        t = '0; t.op = isss_pkg::OP_START; t.pan_pair = 16'h807F; t.wave_pair = 16'h10F0;
        t.hold_frames = 8'd2; t.step_total = 8'd3; t.repeat_req = 1'b1;
        t.attack_pair = 16'h55AA; t.decay_pair = 16'hAA55;
        pending_requests.push_back(t);
        t = random_start(4, 1);
        pending_requests.push_back(t);
        t = random_start(4, 1);
        pending_requests.push_back(t);
        for (int k = 0; k < 8; k++)
        begin
            t = '0; t.op = isss_pkg::OP_TICK;
            pending_requests.push_back(t);
        end
        t = '0; t.op = 2'd3; t.slot = 2'd1;
        pending_requests.push_back(t);
        for (int s = 0; s < NSLOT; s++)
        begin
            t = '1; t.op = isss_pkg::OP_STOP; t.slot = 2'(s);
            pending_requests.push_back(t);
        end
        t = random_start(1, 0);
        pending_requests.push_back(t);
        t = '0; t.op = isss_pkg::OP_TICK;
        pending_requests.push_back(t);

        // Random: mostly starts and ticks, with some stops and stray ops.
        for (int k = 0; k < 330; k++)
        begin
            kind_pick = $urandom_range(99);
            t = isss_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
            if (kind_pick < 25)
                t = random_start(($urandom_range(9) == 0) ? 255 : 6,
                                 ($urandom_range(9) == 0) ? 255 : 3);
            else if (kind_pick < 30)
                t.op = isss_pkg::OP_START;
            else if (kind_pick < 40)
                t.op = isss_pkg::OP_STOP;
            else if (kind_pick < 43)
                t.op = 2'd3;
            else
                t.op = isss_pkg::OP_TICK;
            pending_requests.push_back(t);
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("tb_interpolated_sound_sweep_sequencer: PASS");
        else
            $display("tb_interpolated_sound_sweep_sequencer: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
